[hdl/tzv_pkg.sv]
// Shared types and constants for the timed zone valve controller.
package tzv_pkg;

  localparam int unsigned DUR_W    = 27;
  localparam int unsigned DEB_W    = 16;
  localparam int unsigned SINCE_W  = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [DUR_W-1:0]   DUR_RESET   = 27'd600000;
  localparam logic [DEB_W-1:0]   DEB_RESET   = 16'd200;
  localparam logic [SINCE_W-1:0] SINCE_SAT   = 17'd65536;
  localparam logic [DUR_W-1:0]   ELAPSED_MAX = {DUR_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd1;

  // One tick request.
  typedef struct packed {
    logic inhibit;
    logic remote_state;
    logic remote_valid;
    logic button_edge;
  } tick_t;

  // One tick result.
  typedef struct packed {
    logic [DUR_W-1:0] remaining_ms;
    logic             button_state;
    logic             relay_on;
  } result_t;

endpackage

[hdl/tzv_step.sv]
// Zone state registers and the per-tick update logic.
module tzv_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  tzv_pkg::tick_t                tick,
  input  logic [tzv_pkg::DUR_W-1:0]     duration_ms,
  input  logic [tzv_pkg::DEB_W-1:0]     debounce_ms,
  output tzv_pkg::result_t              result
);

  logic                          zone_button_r, zone_button_nxt;
  logic                          relay_active_r, relay_active_nxt;
  logic [tzv_pkg::DUR_W-1:0]     run_elapsed_r, run_elapsed_nxt;
  logic [tzv_pkg::SINCE_W-1:0]   since_edge_r, since_edge_nxt;
  logic [tzv_pkg::DUR_W-1:0]     remaining;
  logic                          edge_ok;

  always_comb begin
    since_edge_nxt   = since_edge_r;
    run_elapsed_nxt  = run_elapsed_r;
    zone_button_nxt  = zone_button_r;
    relay_active_nxt = relay_active_r;
    remaining        = '0;

    if (since_edge_r < tzv_pkg::SINCE_SAT) begin
      since_edge_nxt = since_edge_r + 1'b1;
    end
    if (relay_active_r && (run_elapsed_r != tzv_pkg::ELAPSED_MAX)) begin
      run_elapsed_nxt = run_elapsed_r + 1'b1;
    end

    if (tick.remote_valid) begin
      zone_button_nxt = tick.remote_state;
    end

    // debounce: edge counts only when strictly past the hold-off window
    edge_ok = tick.button_edge && (since_edge_nxt > {1'b0, debounce_ms});
    if (edge_ok) begin
      since_edge_nxt  = '0;
      zone_button_nxt = !zone_button_nxt;
    end

    if (tick.inhibit) begin
      zone_button_nxt  = 1'b0;
      relay_active_nxt = 1'b0;
      run_elapsed_nxt  = '0;
    end else begin
      if (!relay_active_nxt && zone_button_nxt) begin
        relay_active_nxt = 1'b1;
        run_elapsed_nxt  = '0;
      end else if (relay_active_nxt && !zone_button_nxt) begin
        relay_active_nxt = 1'b0;
      end
      if (relay_active_nxt) begin
        if (run_elapsed_nxt < duration_ms) begin
          remaining = duration_ms - run_elapsed_nxt;
        end else begin
          relay_active_nxt = 1'b0;
          zone_button_nxt  = 1'b0;
        end
      end
    end

    result.relay_on     = relay_active_nxt;
    result.button_state = zone_button_nxt;
    result.remaining_ms = remaining;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_button_r  <= 1'b0;
      relay_active_r <= 1'b0;
      run_elapsed_r  <= '0;
      since_edge_r   <= tzv_pkg::SINCE_SAT;
    end else if (step_en) begin
      zone_button_r  <= zone_button_nxt;
      relay_active_r <= relay_active_nxt;
      run_elapsed_r  <= run_elapsed_nxt;
      since_edge_r   <= since_edge_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_relay_needs_button: assert property (@(posedge clk) disable iff (!rst_n)
    relay_active_r |-> zone_button_r)
    else $error("relay on with button off");

  a_since_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    since_edge_r <= tzv_pkg::SINCE_SAT)
    else $error("edge counter past saturation");

  a_inhibit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && tick.inhibit |=> !relay_active_r && !zone_button_r && (run_elapsed_r == '0))
    else $error("inhibit did not clear zone");

  a_off_no_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    !result.relay_on |-> (result.remaining_ms == '0))
    else $error("remaining time with relay off");
`endif

endmodule

[hdl/timed_zone_valve_controller_core.sv]
// Top level of the timed zone valve controller: stream ports, config, stage registers.
// Each request is one millisecond tick and yields exactly one result. The block
// runs at one tick per clock while the result side is not stalled: a request is
// held in the input register, the zone update (debounce compare, run timer compare
// and subtract) runs in one pass of logic, and the result lands in the output
// register, which drives out_tvalid. Both stages advance together whenever the
// output register is empty or being drained, so back-to-back requests flow with no
// gap; a stall on the result side backs up into in_tready in the same cycle.
// Configuration writes (duration, debounce) take effect on the next tick and must
// be made while no request is in flight.
module timed_zone_valve_controller_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] button_edge, [1] remote_valid, [2] remote_state, [3] inhibit, [7:4] zero
  input  logic [tzv_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] relay_on, [1] button_state, [28:2] remaining_ms, [31:29] zero
  output logic [tzv_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [tzv_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [tzv_pkg::DUR_W-1:0]           cfg_data
);

  logic [tzv_pkg::DUR_W-1:0] duration_r;
  logic [tzv_pkg::DEB_W-1:0] debounce_r;

  logic             in_valid_r;
  tzv_pkg::tick_t   in_tick_r;
  logic             out_valid_r;
  tzv_pkg::result_t out_res_r;
  tzv_pkg::result_t step_res;

  logic out_free;
  logic advance;

  // output slot can take a new result when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r <= tzv_pkg::DUR_RESET;
      debounce_r <= tzv_pkg::DEB_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        tzv_pkg::REG_DURATION: duration_r <= cfg_data;
        tzv_pkg::REG_DEBOUNCE: debounce_r <= cfg_data[tzv_pkg::DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_tick_r.button_edge  <= in_tdata[0];
      in_tick_r.remote_valid <= in_tdata[1];
      in_tick_r.remote_state <= in_tdata[2];
      in_tick_r.inhibit      <= in_tdata[3];
    end
  end

  // state update commits only when the tick moves into the output slot
  tzv_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .tick        (in_tick_r),
    .duration_ms (duration_r),
    .debounce_ms (debounce_r),
    .result      (step_res)
  );

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.remaining_ms, out_res_r.button_state,
                       out_res_r.relay_on};

endmodule
